### rtl/ppt_pkg.sv
// shared types and constants for the pulse period tachometer
package ppt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_W = 34;
  localparam int DIVS_W = 32;
  localparam int STEP_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_PPR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_RISING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 3'd4;

  localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF;
  localparam logic [23:0] RESET_TIMEOUT_US = 24'd1000000;
  localparam logic [DIV_W-1:0] RPM_NUM_Q8 = 34'd15360000000;

  localparam logic [STEP_W-1:0] STEPS_QUOT = 6'd8;
  localparam logic [STEP_W-1:0] STEPS_RPM = 6'd34;

  typedef struct packed {
    logic [7:0]  pulses_per_rev;
    logic [7:0]  pulses_per_measure;
    logic [23:0] timeout_us;
    logic        edge_rising;
    logic        enabled;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

### rtl/ppt_track.sv
// edge detection, interval timer, edge counting and timeout tracking
module ppt_track (
  input  logic            clk,
  input  logic            rst_n,
  input  ppt_pkg::cfg_t   cfg,
  input  logic            accept,
  input  logic            pin_level,
  output logic [31:0]     last_period,
  output logic            latched
);

  logic        prev_r, prev_nxt;
  logic [31:0] timer_r, timer_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        started_r, started_nxt;
  logic [23:0] tmo_r, tmo_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] period_r, period_nxt;
  logic        latched_r, latched_nxt;

  logic        edge_seen;
  logic [31:0] timer_inc;
  logic [31:0] timer_base;
  logic [7:0]  count_base;
  logic [7:0]  count_inc;
  logic [7:0]  eff_measure;

  always_comb begin
    eff_measure = (cfg.pulses_per_measure == 8'd0) ? 8'd1 : cfg.pulses_per_measure;
    edge_seen   = cfg.edge_rising ? (!prev_r && pin_level) : (prev_r && !pin_level);
    timer_inc   = (cfg.enabled && timer_r != ppt_pkg::TIMER_MAX) ? timer_r + 32'd1 : timer_r;
    timer_base  = started_r ? timer_inc : 32'd0;
    count_base  = started_r ? count_r : 8'd0;
    count_inc   = count_base + 8'd1;

    prev_nxt    = pin_level;
    timer_nxt   = timer_inc;
    count_nxt   = count_r;
    started_nxt = started_r;
    tmo_nxt     = tmo_r;
    armed_nxt   = armed_r;
    period_nxt  = period_r;
    latched_nxt = 1'b0;

    if (cfg.enabled && edge_seen) begin
      started_nxt = 1'b1;
      if (count_inc == eff_measure) begin
        period_nxt  = timer_base;
        timer_nxt   = 32'd0;
        count_nxt   = 8'd0;
        latched_nxt = 1'b1;
      end else begin
        timer_nxt = timer_base;
        count_nxt = count_inc;
      end
      tmo_nxt   = cfg.timeout_us;
      armed_nxt = 1'b1;
    end else if (armed_r) begin
      if (tmo_r <= 24'd1) begin
        tmo_nxt    = 24'd0;
        armed_nxt  = 1'b0;
        period_nxt = 32'd0;
      end else begin
        tmo_nxt = tmo_r - 24'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= 1'b0;
      timer_r   <= 32'd0;
      count_r   <= 8'd0;
      started_r <= 1'b0;
      tmo_r     <= 24'd0;
      armed_r   <= 1'b0;
      period_r  <= 32'd0;
      latched_r <= 1'b0;
    end else if (accept) begin
      prev_r    <= prev_nxt;
      timer_r   <= timer_nxt;
      count_r   <= count_nxt;
      started_r <= started_nxt;
      tmo_r     <= tmo_nxt;
      armed_r   <= armed_nxt;
      period_r  <= period_nxt;
      latched_r <= latched_nxt;
    end
  end

  assign last_period = period_r;
  assign latched     = latched_r;

endmodule

### rtl/ppt_div.sv
// restoring divider, one quotient bit per cycle, step count set per run
module ppt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppt_pkg::div_req_t             req,
  input  logic [ppt_pkg::DIV_W-1:0]     dividend,
  input  logic [ppt_pkg::DIVS_W-1:0]    divisor,
  output ppt_pkg::div_rsp_t             rsp,
  output logic [ppt_pkg::DIV_W-1:0]     quotient
);

  logic [ppt_pkg::DIV_W-1:0]  dvd_r;
  logic [ppt_pkg::DIVS_W-1:0] dvs_r;
  logic [ppt_pkg::DIVS_W-1:0] rem_r;
  logic [ppt_pkg::DIV_W-1:0]  quo_r;
  logic [ppt_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ppt_pkg::DIVS_W:0]   trial;
  logic [ppt_pkg::DIVS_W:0]   diff;
  logic                       ge;
  logic [ppt_pkg::DIVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[ppt_pkg::DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[ppt_pkg::DIVS_W-1:0] : trial[ppt_pkg::DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ppt_pkg::STEP_W'(1);
        if (cnt_r == ppt_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: the dividend is left aligned so its top bit enters first
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ppt_pkg::DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ppt_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quotient = quo_r;

endmodule

### rtl/pulse_period_tachometer.sv
// Pulse period tachometer: one pin sample per item, period, rotation time and rpm out.
// Each accepted item updates edge, timer and timeout state in its accept cycle, then a
// sequencer runs one shared restoring divider twice: 8 steps for the integer quotient
// pulses_per_rev / pulses_per_measure, a product state for the saturating 32x8 rotation time
// product, then 34 steps for rpm = 15360000000 / rotation_time (0 for a zero rotation
// time). With the divider running one bit per cycle, each divider run has a start and a done
// step around it, followed by the product state and the output load; in_stall is high from
// the accept until the result is loaded, which waits longer while out_stall holds the output
// register, and the next item is taken only after that.
// Results sit in an output register, so the next item is taken while an earlier result
// still waits on out_stall. Configuration writes are expected only while the block is idle.
module pulse_period_tachometer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_pin_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_period_us,
  output logic [31:0]                       out_rotation_time_us,
  output logic [33:0]                       out_rpm_q8,
  output logic                              out_new_measurement
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVQ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIVR = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  ppt_pkg::cfg_t cfg_r;

  logic [2:0]  state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [7:0]  quot_r;
  logic [31:0] rot_r;
  logic [33:0] rpm_r;
  logic        out_valid_r;

  logic        accept;
  logic        out_load;
  logic [31:0] last_period;
  logic        latched;
  logic [39:0] product;
  logic [7:0]  eff_measure;

  ppt_pkg::div_req_t           div_req;
  ppt_pkg::div_rsp_t           div_rsp;
  logic [ppt_pkg::DIV_W-1:0]   div_dividend;
  logic [ppt_pkg::DIVS_W-1:0]  div_divisor;
  logic [ppt_pkg::DIV_W-1:0]   div_quotient;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulses_per_rev     <= 8'd1;
      cfg_r.pulses_per_measure <= 8'd1;
      cfg_r.timeout_us         <= ppt_pkg::RESET_TIMEOUT_US;
      cfg_r.edge_rising        <= 1'b1;
      cfg_r.enabled            <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppt_pkg::CFG_PPR:         cfg_r.pulses_per_rev     <= cfg_data[7:0];
        ppt_pkg::CFG_PPM:         cfg_r.pulses_per_measure <= cfg_data[7:0];
        ppt_pkg::CFG_TIMEOUT:     cfg_r.timeout_us         <= cfg_data;
        ppt_pkg::CFG_EDGE_RISING: cfg_r.edge_rising        <= cfg_data[0];
        ppt_pkg::CFG_ENABLED:     cfg_r.enabled            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ppt_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .pin_level   (in_pin_level),
    .last_period (last_period),
    .latched     (latched)
  );

  always_comb begin
    eff_measure = (cfg_r.pulses_per_measure == 8'd0) ? 8'd1 : cfg_r.pulses_per_measure;
    div_req.start = go_r;
    if (state_r == S_DIVQ) begin
      div_req.steps = ppt_pkg::STEPS_QUOT;
      div_dividend  = {cfg_r.pulses_per_rev, 26'd0};
      div_divisor   = {24'd0, eff_measure};
    end else begin
      div_req.steps = ppt_pkg::STEPS_RPM;
      div_dividend  = ppt_pkg::RPM_NUM_Q8;
      div_divisor   = rot_r;
    end
  end

  ppt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quotient (div_quotient)
  );

  assign product = last_period * {32'd0, quot_r};

  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DIVQ;
          go_nxt    = 1'b1;
        end
      end
      S_DIVQ: begin
        if (div_rsp.done) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIVR;
        go_nxt    = 1'b1;
      end
      S_DIVR: begin
        if (div_rsp.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIVQ && div_rsp.done) begin
      quot_r <= div_quotient[7:0];
    end
    if (state_r == S_MUL) begin
      // saturate the rotation time at the 32-bit maximum
      rot_r <= (product[39:32] != 8'd0) ? ppt_pkg::TIMER_MAX : product[31:0];
    end
    if (state_r == S_DIVR && div_rsp.done) begin
      rpm_r <= (rot_r == 32'd0) ? 34'd0 : div_quotient;
    end
    if (out_load) begin
      out_period_us        <= last_period;
      out_rotation_time_us <= rot_r;
      out_rpm_q8           <= rpm_r;
      out_new_measurement  <= latched;
    end
  end

  assign out_valid = out_valid_r;

endmodule
